FILE: hw/rtl/nsfc_pkg.sv
// Shared types, character codes and prefix table for the NMEA sentence framer/checker.
package nsfc_pkg;

   localparam int MaxTextDefault = 128;
   localparam int QueueDepth     = 2;
   localparam int PrefixLen      = 6;
   localparam int KindCount      = 6;

   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharLf     = 8'h0A;
   localparam logic [7:0] CharNul    = 8'h00;

   localparam logic [1:0] KindOther = 2'd0;
   localparam logic [1:0] KindGga   = 2'd1;
   localparam logic [1:0] KindRmc   = 2'd2;
   localparam logic [1:0] KindGsa   = 2'd3;

   // Row order: GPGGA, GNGGA, GPRMC, GNRMC, GPGSA, GNGSA
   localparam logic [7:0] PrefixTable [KindCount][PrefixLen] = '{
      '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
      '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h47, 8'h41},
      '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
      '{8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43},
      '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
      '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h53, 8'h41}
   };

   typedef struct packed {
      logic       sentence_ok;
      logic [1:0] sentence_kind;
      logic [7:0] computed_sum;
      logic [7:0] stated_sum;
      logic [6:0] text_length;
   } nsfc_record_type;

   typedef struct packed {
      logic            valid;
      nsfc_record_type record;
   } nsfc_push_type;

   // Returns {is_digit, value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] result;
      result = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         result = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         result = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         result = {1'b1, 4'(c - 8'h57)};
      end
      return result;
   endfunction

endpackage

FILE: hw/rtl/nsfc_front.sv
// Front end: frames sentences byte by byte and builds one record per sentence end.
module nsfc_front #(
   parameter int MAX_TEXT = nsfc_pkg::MaxTextDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             rx_byte,
   output nsfc_pkg::nsfc_push_type push
);
   import nsfc_pkg::*;

   localparam int CountW = $clog2(MAX_TEXT);
   localparam logic [CountW-1:0] CountLimit = CountW'(MAX_TEXT - 1);

   logic [CountW-1:0]    count_ff, count_in;
   logic [7:0]           xor_ff, xor_in;
   logic                 star_ff, star_in;
   logic [7:0]           hex_ff, hex_in;
   logic                 hex_stop_ff, hex_stop_in;
   logic                 ended_ff, ended_in;
   logic                 dollar_ff, dollar_in;
   logic [KindCount-1:0] mask_ff, mask_in;

   logic       is_eol;
   logic       sum_ok;
   logic [1:0] kind;
   logic [4:0] digit;
   logic [2:0] pos;
   logic [7:0] len_wide;

   assign is_eol   = (rx_byte == CharCr) || (rx_byte == CharLf);
   assign digit    = hex_digit(rx_byte);
   assign pos      = 3'(count_ff);
   assign len_wide = 8'(count_ff);
   assign sum_ok   = dollar_ff && star_ff && (xor_ff == hex_ff);

   always_comb begin
      kind = KindOther;
      if (sum_ok && count_ff >= CountW'(PrefixLen)) begin
         priority if (|mask_ff[1:0]) begin
            kind = KindGga;
         end else if (|mask_ff[3:2]) begin
            kind = KindRmc;
         end else if (|mask_ff[5:4]) begin
            kind = KindGsa;
         end else begin
            kind = KindOther;
         end
      end
   end

   assign push.record.sentence_ok   = sum_ok;
   assign push.record.sentence_kind = kind;
   assign push.record.computed_sum  = xor_ff;
   assign push.record.stated_sum    = hex_ff;
   assign push.record.text_length   = len_wide[6:0];
   assign push.valid = take && is_eol && (count_ff != '0);

   always_comb begin
      count_in    = count_ff;
      xor_in      = xor_ff;
      star_in     = star_ff;
      hex_in      = hex_ff;
      hex_stop_in = hex_stop_ff;
      ended_in    = ended_ff;
      dollar_in   = dollar_ff;
      mask_in     = mask_ff;
      if (take) begin
         priority if (rx_byte == CharDollar) begin
            count_in    = CountW'(1);
            xor_in      = '0;
            star_in     = 1'b0;
            hex_in      = '0;
            hex_stop_in = 1'b0;
            ended_in    = 1'b0;
            dollar_in   = 1'b1;
            mask_in     = '1;
         end else if (is_eol) begin
            if (count_ff != '0) begin
               count_in    = '0;
               xor_in      = '0;
               star_in     = 1'b0;
               hex_in      = '0;
               hex_stop_in = 1'b0;
               ended_in    = 1'b0;
               dollar_in   = 1'b0;
               mask_in     = '1;
            end
         end else if (count_ff < CountLimit) begin
            count_in = count_ff + CountW'(1);
            if (count_ff == '0) begin
               dollar_in = 1'b0;
            end
            if (!ended_ff) begin
               if (count_ff < CountW'(PrefixLen)) begin
                  for (int i = 0; i < KindCount; i++) begin
                     if (PrefixTable[i][pos] != rx_byte) begin
                        mask_in[i] = 1'b0;
                     end
                  end
               end
               // A zero byte freezes sums, star flag and prefix match
               if (rx_byte == CharNul) begin
                  ended_in = 1'b1;
               end else if (!star_ff) begin
                  if (rx_byte == CharStar) begin
                     star_in = 1'b1;
                  end else if (count_ff != '0) begin
                     xor_in = xor_ff ^ rx_byte;
                  end
               end else if (!hex_stop_ff) begin
                  if (!digit[4]) begin
                     hex_stop_in = 1'b1;
                  end else begin
                     hex_in = {hex_ff[3:0], digit[3:0]};
                  end
               end
            end
         end else begin
            // drop bytes beyond the text limit
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         xor_ff      <= '0;
         star_ff     <= 1'b0;
         hex_ff      <= '0;
         hex_stop_ff <= 1'b0;
         ended_ff    <= 1'b0;
         dollar_ff   <= 1'b0;
         mask_ff     <= '1;
      end else begin
         count_ff    <= count_in;
         xor_ff      <= xor_in;
         star_ff     <= star_in;
         hex_ff      <= hex_in;
         hex_stop_ff <= hex_stop_in;
         ended_ff    <= ended_in;
         dollar_ff   <= dollar_in;
         mask_ff     <= mask_in;
      end
   end

endmodule

FILE: hw/rtl/nsfc_queue.sv
// Short record queue between the framing front end and the result back end.
module nsfc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  nsfc_pkg::nsfc_push_type   push,
   output logic                      full,
   input  logic                      pop,
   output logic                      out_valid,
   output nsfc_pkg::nsfc_record_type out_record
);
   import nsfc_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   nsfc_record_type         entry_ff [QueueDepth];
   logic [PtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]           fill_ff, fill_in;
   logic                    do_push;
   logic                    do_pop;

   assign full       = (fill_ff == (PtrW+1)'(QueueDepth));
   assign out_valid  = (fill_ff != '0);
   assign out_record = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + (PtrW+1)'(1);
         2'b01:   fill_in = fill_ff - (PtrW+1)'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.record;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: hw/rtl/nsfc_back.sv
// Back end: keeps the sentence counters and drives the registered result beat.
module nsfc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  nsfc_pkg::nsfc_record_type q_record,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_sentence_ok,
   output logic [1:0]                rsp_sentence_kind,
   output logic [7:0]                rsp_computed_sum,
   output logic [7:0]                rsp_stated_sum,
   output logic [6:0]                rsp_text_length,
   output logic [31:0]               rsp_received_total,
   output logic [31:0]               rsp_passed_total
);
   import nsfc_pkg::*;

   logic            valid_ff, valid_in;
   logic [31:0]     received_ff, received_in;
   logic [31:0]     passed_ff, passed_in;
   nsfc_record_type record_ff;

   // Load a new beat when the output register is empty or being taken
   assign q_pop = q_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in    = valid_ff;
      received_in = received_ff;
      passed_in   = passed_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (q_pop) begin
         valid_in    = 1'b1;
         received_in = received_ff + 32'd1;
         passed_in   = passed_ff + 32'(q_record.sentence_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         record_ff <= q_record;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         received_ff <= '0;
         passed_ff   <= '0;
      end else begin
         valid_ff    <= valid_in;
         received_ff <= received_in;
         passed_ff   <= passed_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_sentence_ok    = record_ff.sentence_ok;
   assign rsp_sentence_kind  = record_ff.sentence_kind;
   assign rsp_computed_sum   = record_ff.computed_sum;
   assign rsp_stated_sum     = record_ff.stated_sum;
   assign rsp_text_length    = record_ff.text_length;
   assign rsp_received_total = received_ff;
   assign rsp_passed_total   = passed_ff;

endmodule

FILE: hw/rtl/nmea_sentence_framer_checker.sv
// Top level of the NMEA sentence framer and checksum checker.
// Takes one received character per cycle while req_stall is low and gives one result
// beat for each CR or LF that closes a non-empty sentence: checksum verdict, sentence
// kind, both sums, stored length and the running sentence counters. Every character is
// taken by the framing front end, so a byte stream may run at one byte per clock while
// req_stall is low; results pass through a two-entry queue and an output register, and
// req_stall rises only when that queue is full because the result side has been stalling.
// A closing CR/LF's record is registered in the queue, then in the output register.
module nmea_sentence_framer_checker #(
   parameter int MAX_TEXT = nsfc_pkg::MaxTextDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sentence_ok,
   output logic [1:0]  rsp_sentence_kind,
   output logic [7:0]  rsp_computed_sum,
   output logic [7:0]  rsp_stated_sum,
   output logic [6:0]  rsp_text_length,
   output logic [31:0] rsp_received_total,
   output logic [31:0] rsp_passed_total
);
   import nsfc_pkg::*;

   nsfc_push_type   push;
   nsfc_record_type q_record;
   logic            q_full;
   logic            q_valid;
   logic            q_pop;
   logic            take;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   nsfc_front #(
      .MAX_TEXT(MAX_TEXT)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .push    (push)
   );

   nsfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (q_full),
      .pop        (q_pop),
      .out_valid  (q_valid),
      .out_record (q_record)
   );

   nsfc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_record           (q_record),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sentence_ok    (rsp_sentence_ok),
      .rsp_sentence_kind  (rsp_sentence_kind),
      .rsp_computed_sum   (rsp_computed_sum),
      .rsp_stated_sum     (rsp_stated_sum),
      .rsp_text_length    (rsp_text_length),
      .rsp_received_total (rsp_received_total),
      .rsp_passed_total   (rsp_passed_total)
   );

endmodule
